// ----- sv/ascp_pkg.sv -----
// Shared types and constants for the Ascon permutation pipeline.
`default_nettype none
package ascp_pkg;

	localparam int WORD_W      = 64;
	localparam int NUM_WORDS   = 5;
	localparam int COUNT_W     = 4;
	// Round constants are indexed 0..CONST_COUNT-1; n rounds use the last n.
	localparam int CONST_COUNT = 12;

	typedef struct packed {
		logic [WORD_W-1:0]  word_in_0;
		logic [WORD_W-1:0]  word_in_1;
		logic [WORD_W-1:0]  word_in_2;
		logic [WORD_W-1:0]  word_in_3;
		logic [WORD_W-1:0]  word_in_4;
		logic [COUNT_W-1:0] round_count;
	} in_word_t;

	typedef struct packed {
		logic [WORD_W-1:0] word_out_0;
		logic [WORD_W-1:0] word_out_1;
		logic [WORD_W-1:0] word_out_2;
		logic [WORD_W-1:0] word_out_3;
		logic [WORD_W-1:0] word_out_4;
	} out_word_t;

	typedef logic [NUM_WORDS-1:0][WORD_W-1:0] state_t;

	// What travels down the pipe: the state and the saturated round count.
	typedef struct packed {
		state_t             words;
		logic [COUNT_W-1:0] rounds;
	} stage_t;

	// Constant i is ((15 - i) << 4) | i.
	function automatic logic [7:0] round_constant(input logic [COUNT_W-1:0] idx);
		return {~idx, idx};
	endfunction

endpackage
`default_nettype wire

// ----- sv/ascp_round.sv -----
// One Ascon round: constant addition, substitution layer, linear layer.
`default_nettype none
module ascp_round (
	input  wire logic                          apply,
	input  wire logic [ascp_pkg::COUNT_W-1:0]  cidx,
	input  wire ascp_pkg::state_t              din,
	output ascp_pkg::state_t                   dout
);

	logic [ascp_pkg::WORD_W-1:0] a0, a1, a2, a3, a4;
	logic [ascp_pkg::WORD_W-1:0] t0, t1, t2, t3, t4;
	logic [ascp_pkg::WORD_W-1:0] n0, n1, n2, n3, n4;
	ascp_pkg::state_t            rnd;

	always_comb begin
		// constant into word 2, then the input XORs of the sbox
		a0 = din[0] ^ din[4];
		a4 = din[4] ^ din[3];
		a2 = din[2] ^ {{(ascp_pkg::WORD_W-8){1'b0}}, ascp_pkg::round_constant(cidx)} ^ din[1];
		a1 = din[1];
		a3 = din[3];

		t0 = a0 ^ (~a1 & a2);
		t1 = a1 ^ (~a2 & a3);
		t2 = a2 ^ (~a3 & a4);
		t3 = a3 ^ (~a4 & a0);
		t4 = a4 ^ (~a0 & a1);

		n0 = t0 ^ t4;
		n1 = t1 ^ t0;
		n2 = ~t2;
		n3 = t3 ^ t2;
		n4 = t4;

		rnd[0] = n0 ^ {n0[18:0], n0[63:19]} ^ {n0[27:0], n0[63:28]};
		rnd[1] = n1 ^ {n1[60:0], n1[63:61]} ^ {n1[38:0], n1[63:39]};
		rnd[2] = n2 ^ {n2[0],    n2[63:1]}  ^ {n2[5:0],  n2[63:6]};
		rnd[3] = n3 ^ {n3[9:0],  n3[63:10]} ^ {n3[16:0], n3[63:17]};
		rnd[4] = n4 ^ {n4[6:0],  n4[63:7]}  ^ {n4[40:0], n4[63:41]};

		dout = apply ? rnd : din;
	end

endmodule
`default_nettype wire

// ----- sv/ascp_stage.sv -----
// One pipeline stage: a round unit followed by a valid/data register.
`default_nettype none
module ascp_stage #(
	parameter int MAX_ROUNDS = 12,
	parameter int STAGE      = 0
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             up_valid,
	input  wire ascp_pkg::stage_t up_data,
	output logic                  up_ready,
	output logic                  dn_valid,
	output ascp_pkg::stage_t      dn_data,
	input  wire logic             dn_ready
);

	// Constant index this stage uses, and the least count that reaches it.
	localparam int CIDX     = ascp_pkg::CONST_COUNT - MAX_ROUNDS + STAGE;
	localparam int MIN_RNDS = MAX_ROUNDS - STAGE;

	logic             valid_s;
	ascp_pkg::stage_t data_s;
	logic             apply;
	ascp_pkg::state_t next_words;

	assign apply = {1'b0, up_data.rounds} >= (ascp_pkg::COUNT_W+1)'(MIN_RNDS);

	ascp_round u_round (
		.apply (apply),
		.cidx  (ascp_pkg::COUNT_W'(CIDX)),
		.din   (up_data.words),
		.dout  (next_words)
	);

	assign up_ready = !valid_s || dn_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s <= 1'b0;
		end else if (up_ready) begin
			valid_s <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			data_s.words  <= next_words;
			data_s.rounds <= up_data.rounds;
		end
	end

	assign dn_valid = valid_s;
	assign dn_data  = data_s;

endmodule
`default_nettype wire

// ----- sv/ascon_permutation_top.sv -----
// Ascon p permutation over a 320-bit state, fully unrolled pipeline.
`default_nettype none
// Takes the five 64-bit state words and a round count per word and returns the
// permuted state. Each of the MAX_ROUNDS pipeline stages holds one round unit,
// stage k adding round constant CONST_COUNT-MAX_ROUNDS+k; a word asking for n
// rounds passes untouched through the first MAX_ROUNDS-n stages. Each word
// moves through the stage registers in order; the last stage's register
// drives result and holds the word while result_stall is high. A new word
// may enter on every clock while item_stall is low. A count of zero returns
// the input words; counts above MAX_ROUNDS are treated as MAX_ROUNDS.
// Each stage keeps its own valid bit and takes a new word whenever it is empty
// or its contents move on, so bubbles close up while the result side stalls;
// item_stall rises only once every stage is full and result_stall is high.
// The depth of one stage is one round: a constant XOR, the bitsliced sbox and
// a three-input XOR of rotations.
module ascon_permutation_top #(
	parameter int MAX_ROUNDS = 12
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               item_valid,
	input  wire ascp_pkg::in_word_t item,
	output logic                    item_stall,
	output logic                    result_valid,
	output ascp_pkg::out_word_t     result,
	input  wire logic               result_stall
);

	logic [MAX_ROUNDS:0]   vld;
	logic [MAX_ROUNDS:0]   rdy;
	ascp_pkg::stage_t      pipe [MAX_ROUNDS+1];
	logic [ascp_pkg::COUNT_W-1:0] sat_count;

	// saturate the count to the pipeline depth
	assign sat_count = (item.round_count > ascp_pkg::COUNT_W'(MAX_ROUNDS))
		? ascp_pkg::COUNT_W'(MAX_ROUNDS) : item.round_count;

	assign vld[0]          = item_valid;
	assign pipe[0].words   = {item.word_in_4, item.word_in_3, item.word_in_2,
		item.word_in_1, item.word_in_0};
	assign pipe[0].rounds  = sat_count;
	assign item_stall      = !rdy[0];

	for (genvar k = 0; k < MAX_ROUNDS; k++) begin : g_stage
		ascp_stage #(
			.MAX_ROUNDS (MAX_ROUNDS),
			.STAGE      (k)
		) u_stage (
			.clk      (clk),
			.arst_n   (arst_n),
			.up_valid (vld[k]),
			.up_data  (pipe[k]),
			.up_ready (rdy[k]),
			.dn_valid (vld[k+1]),
			.dn_data  (pipe[k+1]),
			.dn_ready (rdy[k+1])
		);
	end

	assign rdy[MAX_ROUNDS] = !result_stall;
	assign result_valid    = vld[MAX_ROUNDS];
	assign result.word_out_0 = pipe[MAX_ROUNDS].words[0];
	assign result.word_out_1 = pipe[MAX_ROUNDS].words[1];
	assign result.word_out_2 = pipe[MAX_ROUNDS].words[2];
	assign result.word_out_3 = pipe[MAX_ROUNDS].words[3];
	assign result.word_out_4 = pipe[MAX_ROUNDS].words[4];

	// back-pressure only comes from the result side
	a_stall_source: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> result_stall)
		else $error("input stalled without output stall");

	// input stalls only when every stage holds a word
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> ($countones(vld[MAX_ROUNDS:1]) == MAX_ROUNDS))
		else $error("input stalled with a free stage");

	// a word left waiting at the output is still there next cycle
	a_result_kept: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result_stall) |=> result_valid)
		else $error("stalled result dropped");

endmodule
`default_nettype wire

// ----- sim/tb_ascon_permutation_top.sv -----
// Self-checking testbench for the Ascon p permutation pipeline.
`timescale 1ns / 1ps
module tb_ascon_permutation_top;

	// Must match the block's MAX_ROUNDS; a count above it saturates.
	localparam int ROUND_LIMIT  = 12;
	localparam int RANDOM_ITEMS = 1100;
	localparam int HOLD_CYCLES  = 100;   // long receiver hold-off, well past pipe depth
	localparam int WATCHDOG     = 2000;  // cycles with no word moving on either side
	localparam int TAIL_CYCLES  = 30;    // pipe depth plus margin

	// Traffic phases. Each queued word carries its phase, and the phase sets
	// how often the sender idles and the receiver stalls.
	typedef enum logic [2:0] {
		PH_FREE,
		PH_HOLD,
		PH_SEND_IDLE,
		PH_RECV_STALL,
		PH_BOTH
	} phase_e;

	typedef struct packed {
		ascp_pkg::in_word_t payload;
		phase_e             phase;
		logic               drain_first;  // hold this word back until the pipe is empty
	} queued_word_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                item_valid = 1'b0;
	ascp_pkg::in_word_t  item = '0;
	logic                item_stall;
	logic                result_valid;
	ascp_pkg::out_word_t result;
	logic                result_stall = 1'b0;

	queued_word_t        words_to_send[$];
	ascp_pkg::out_word_t permuted_due[$];   // predicted states, oldest first

	phase_e cur_phase = PH_FREE;
	int     n_sent = 0;   // words accepted at the input
	int     n_recv = 0;   // words accepted at the output
	int     errs = 0;

	ascon_permutation_top #(
		.MAX_ROUNDS(ROUND_LIMIT)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item(item),
		.item_stall(item_stall),
		.result_valid(result_valid),
		.result(result),
		.result_stall(result_stall)
	);

	always #2 clk = ~clk;

	function automatic logic [63:0] ror(logic [63:0] v, int r);
		return (v >> r) | (v << (64 - r));
	endfunction

	// Predicted permutation: n rounds use constants 12-n .. 11, constant i
	// being ((15 - i) << 4) | i. Counts above the limit saturate, zero passes
	// the state through.
	function automatic ascp_pkg::out_word_t ascon_p(ascp_pkg::in_word_t w);
		logic [63:0]         x0, x1, x2, x3, x4;
		logic [63:0]         t0, t1, t2, t3, t4;
		logic [3:0]          ci;
		int                  n;
		ascp_pkg::out_word_t r;
		x0 = w.word_in_0;
		x1 = w.word_in_1;
		x2 = w.word_in_2;
		x3 = w.word_in_3;
		x4 = w.word_in_4;
		n = (w.round_count > ROUND_LIMIT) ? ROUND_LIMIT : int'(w.round_count);
		for (int k = ascp_pkg::CONST_COUNT - n; k < ascp_pkg::CONST_COUNT; k++) begin
			ci = 4'(k);
			x2 ^= {56'd0, 4'd15 - ci, ci};
			// bitsliced sbox
			x0 ^= x4;
			x4 ^= x3;
			x2 ^= x1;
			t0 = x0 ^ (~x1 & x2);
			t1 = x1 ^ (~x2 & x3);
			t2 = x2 ^ (~x3 & x4);
			t3 = x3 ^ (~x4 & x0);
			t4 = x4 ^ (~x0 & x1);
			t1 ^= t0;
			t0 ^= t4;
			t3 ^= t2;
			t2 = ~t2;
			// linear diffusion
			x0 = t0 ^ ror(t0, 19) ^ ror(t0, 28);
			x1 = t1 ^ ror(t1, 61) ^ ror(t1, 39);
			x2 = t2 ^ ror(t2, 1) ^ ror(t2, 6);
			x3 = t3 ^ ror(t3, 10) ^ ror(t3, 17);
			x4 = t4 ^ ror(t4, 7) ^ ror(t4, 41);
		end
		r.word_out_0 = x0;
		r.word_out_1 = x1;
		r.word_out_2 = x2;
		r.word_out_3 = x3;
		r.word_out_4 = x4;
		return r;
	endfunction

	// Percentage of cycles in which the sender (rx = 0) idles or the
	// receiver (rx = 1) stalls, per phase.
	function automatic int unsigned idle_pct(phase_e ph, bit rx);
		case (ph)
			PH_SEND_IDLE:  return rx ? 0 : 57;
			PH_RECV_STALL: return rx ? 57 : 0;
			PH_BOTH:       return 20;
			default:       return 0;
		endcase
	endfunction

	// Mostly random words, now and then all zeros or all ones.
	function automatic logic [63:0] rand_word();
		case ($urandom_range(31))
			0:       return '0;
			1:       return '1;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	function automatic ascp_pkg::in_word_t rand_state(logic [3:0] rounds);
		return {rand_word(), rand_word(), rand_word(), rand_word(), rand_word(), rounds};
	endfunction

	function automatic ascp_pkg::in_word_t flat_state(logic [63:0] w, logic [3:0] rounds);
		return {w, w, w, w, w, rounds};
	endfunction

	// Usual counts are 12, 8 and 6; the rest covers the whole 4-bit field,
	// zero and the saturating counts included.
	function automatic logic [3:0] rand_rounds();
		case ($urandom_range(9))
			0, 1, 2: return 4'd12;
			3:       return 4'd8;
			4:       return 4'd6;
			default: return 4'($urandom_range(15));
		endcase
	endfunction

	task automatic queue_word(ascp_pkg::in_word_t w, phase_e ph, bit drain);
		queued_word_t q;
		q.payload = w;
		q.phase = ph;
		q.drain_first = drain;
		words_to_send.push_back(q);
	endtask

	// Driver. A word accepted at this edge gets its prediction queued; a
	// free slot is refilled from the queue unless the phase asks for an idle
	// cycle or the next word waits for the pipe to drain.
	logic         took;
	logic         go;
	queued_word_t nxt;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
			item <= '0;
			cur_phase <= PH_FREE;
			n_sent <= 0;
		end else begin
			took = item_valid && !item_stall;
			if (took) begin
				permuted_due.push_back(ascon_p(item));
				n_sent <= n_sent + 1;
			end
			if (!item_valid || took) begin
				go = 1'b0;
				if (words_to_send.size() != 0) begin
					nxt = words_to_send[0];
					// counters move by NBA, so a word taken at this edge is
					// not yet in n_sent: hold the word back in that case
					go = !(nxt.drain_first && (took || n_recv != n_sent)) &&
						($urandom_range(99) >= idle_pct(nxt.phase, 1'b0));
				end
				if (go) begin
					item <= nxt.payload;
					cur_phase <= nxt.phase;
					void'(words_to_send.pop_front());
				end
				item_valid <= go;
			end
		end
	end

	// Monitor. Checks each result word against the oldest prediction and
	// sets the stall for the next cycle. On entering the hold phase it stalls
	// for a long stretch while the sender keeps offering, so the pipe fills
	// and item_stall must rise.
	ascp_pkg::state_t want;
	ascp_pkg::state_t got;
	int               hold_left = 0;
	bit               hold_done = 1'b0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_stall <= 1'b0;
			n_recv <= 0;
		end else begin
			if (result_valid && !result_stall) begin
				n_recv <= n_recv + 1;
				if (permuted_due.size() == 0) begin
					$error("result word with nothing expected: %h", result);
					errs++;
				end else begin
					want = ascp_pkg::state_t'(permuted_due.pop_front());
					got = ascp_pkg::state_t'(result);
					// word_out_0 sits in the top 64 bits of the packed struct
					for (int k = 0; k < ascp_pkg::NUM_WORDS; k++) begin
						if (got[ascp_pkg::NUM_WORDS-1-k] !== want[ascp_pkg::NUM_WORDS-1-k])
						begin
							$error("word_out_%0d: expected %h, got %h", k,
								want[ascp_pkg::NUM_WORDS-1-k],
								got[ascp_pkg::NUM_WORDS-1-k]);
							errs++;
						end
					end
				end
			end
			if (hold_left != 0) begin
				hold_left--;
				result_stall <= 1'b1;
			end else if (cur_phase == PH_HOLD && !hold_done) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES - 1;
				result_stall <= 1'b1;
			end else begin
				result_stall <= ($urandom_range(99) < idle_pct(cur_phase, 1'b1));
			end
		end
	end

	// Watchdog: too long without a word moving on either side means a hang.
	int quiet = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if ((item_valid && !item_stall) || (result_valid && !result_stall)) begin
				quiet = 0;
			end else begin
				quiet = quiet + 1;
				if (quiet >= WATCHDOG) begin
					$display("tb_ascon_permutation_top failed");
					$finish;
				end
			end
		end
	end

	// Stimulus and end of run.
	initial begin
		phase_e ph;

		// Directed: flat extremes, alternating bit patterns, then every
		// possible count with random state, zero and saturating counts
		// among them.
		queue_word(flat_state('0, 4'd12), PH_FREE, 1'b0);
		queue_word(flat_state('1, 4'd12), PH_FREE, 1'b0);
		queue_word(flat_state('0, 4'd0), PH_FREE, 1'b0);
		queue_word(flat_state('1, 4'd0), PH_FREE, 1'b0);
		queue_word(flat_state('1, 4'd15), PH_FREE, 1'b0);
		queue_word(flat_state('0, 4'd13), PH_FREE, 1'b0);
		queue_word(flat_state({16{4'h5}}, 4'd8), PH_FREE, 1'b0);
		queue_word(flat_state({16{4'hA}}, 4'd6), PH_FREE, 1'b0);
		for (int c = 0; c < 16; c++)
			queue_word(rand_state(4'(c)), PH_FREE, 1'b0);

		// Random part, split into traffic phases. The sender waits for an
		// empty pipe before the sender-idle phase and the closing free phase.
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i < 150)
				ph = PH_FREE;
			else if (i < 300)
				ph = PH_HOLD;
			else if (i < 500)
				ph = PH_SEND_IDLE;
			else if (i < 700)
				ph = PH_RECV_STALL;
			else if (i < 900)
				ph = PH_BOTH;
			else
				ph = PH_FREE;
			queue_word(rand_state(rand_rounds()), ph, i == 300 || i == 900);
		end

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		while (words_to_send.size() != 0 || item_valid || n_recv != n_sent)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (errs == 0 && permuted_due.size() == 0) begin
			$display("tb_ascon_permutation_top passed");
		end else begin
			$display("tb_ascon_permutation_top failed");
		end
		$finish;
	end

endmodule
